### rtl/core/nrp_pkg.sv
package nrp_pkg;

  // Command codes
  localparam logic [1:0] CMD_ASK     = 2'd0;
  localparam logic [1:0] CMD_FAIL    = 2'd1;
  localparam logic [1:0] CMD_SUCCESS = 2'd2;

  // Action codes
  localparam logic [1:0] ACT_TRY  = 2'd0;
  localparam logic [1:0] ACT_WAIT = 2'd1;
  localparam logic [1:0] ACT_DONE = 2'd2;
  localparam logic [1:0] ACT_ACK  = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NETWORK_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_BUDGET       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PER_ATTEMPT_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_WAIT        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STAY_CONNECTED    = 3'd4;

  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned COUNT_W    = 5;

  // Signed width that holds budget minus any difference of two timestamps
  localparam int unsigned LEFT_W = 50;
  localparam logic signed [LEFT_W-1:0] NO_CAP_MS = {{(LEFT_W-41){1'b0}}, 1'b1, 40'b0};
  localparam logic signed [LEFT_W-1:0] TMO_MIN   = {{(LEFT_W-31){1'b1}}, 31'b0};

  typedef struct packed {
    logic [1:0]        cmd;
    logic [TIME_W-1:0] now_time;
  } nrp_in_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [COUNT_W-1:0] network_index;
    logic signed [31:0] attempt_timeout;
    logic               radio_on;
  } nrp_out_t;

endpackage

### rtl/core/network_retry_planner_core.sv
// Each input transaction passes through the input register, then the result register,
// before its result transaction is offered.
// Throughput: one transaction per cycle while the result side is ready; the planner
// state update and the timeout compare/subtract path both fit between the two registers.
// Reset (async, active low): clears all configuration registers and planner state
// (first pass pending, no pass started, not synced, index 0) and empties both stages.
module network_retry_planner_core #(
  parameter int unsigned MAX_NETWORKS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [nrp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [nrp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  nrp_pkg::nrp_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output nrp_pkg::nrp_out_t                  out_data_o
);
  import nrp_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_NETWORKS + 1);

  // Configuration
  logic [COUNT_W-1:0]    count_q;
  logic [CFG_DATA_W-1:0] budget_q;
  logic [CFG_DATA_W-1:0] limit_q;
  logic [CFG_DATA_W-1:0] retry_q;
  logic                  stay_q;

  // Planner state
  logic              synced_q, synced_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              first_q, first_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic              started_q, started_d;
  logic [TIME_W-1:0] end_q, end_d;
  logic              ended_q, ended_d;

  // Pipeline
  logic     s1_valid_q;
  nrp_in_t  s1_data_q;
  logic     out_valid_q;
  nrp_out_t out_data_q;
  logic     s1_adv;

  // Datapath
  logic [IDX_W-1:0]         size;
  logic signed [LEFT_W-1:0] now_s, budget_s, retry_s, start_diff, end_diff;
  logic signed [LEFT_W-1:0] left_started, left_ask, left_post, tmo_min;
  logic                     ask_done, wait_c, restart;
  logic [1:0]               act;
  logic [COUNT_W-1:0]       idx_out;
  logic                     radio;
  logic signed [31:0]       tmo;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign size = ({{(32-COUNT_W){1'b0}}, count_q} > 32'(MAX_NETWORKS)) ?
                IDX_W'(MAX_NETWORKS) : IDX_W'(count_q);

  assign now_s      = $signed({{(LEFT_W-TIME_W){1'b0}}, s1_data_q.now_time});
  assign budget_s   = $signed({{(LEFT_W-CFG_DATA_W){1'b0}}, budget_q});
  assign retry_s    = $signed({{(LEFT_W-CFG_DATA_W){1'b0}}, retry_q});
  assign start_diff = now_s - $signed({{(LEFT_W-TIME_W){1'b0}}, start_q});
  assign end_diff   = now_s - $signed({{(LEFT_W-TIME_W){1'b0}}, end_q});
  assign left_started = budget_s - start_diff;

  // A pass that starts on this ask has its whole budget left
  assign left_ask = !first_q ? NO_CAP_MS : (!started_q ? budget_s : left_started);
  assign ask_done = (idx_q >= size) || (left_ask <= $signed({LEFT_W{1'b0}}));
  assign wait_c   = ended_q ? (end_diff < retry_s) : (retry_q != '0);

  always_comb begin
    synced_d  = synced_q;
    idx_d     = idx_q;
    first_d   = first_q;
    start_d   = start_q;
    started_d = started_q;
    end_d     = end_q;
    ended_d   = ended_q;
    act       = ACT_ACK;
    idx_out   = '0;
    restart   = 1'b0;
    case (s1_data_q.cmd)
      CMD_ASK: begin
        if (synced_q || size == '0) begin
          act = ACT_DONE;
        end else begin
          if (!started_q) begin
            started_d = 1'b1;
            start_d   = s1_data_q.now_time;
          end
          if (!ask_done) begin
            act     = ACT_TRY;
            idx_out = COUNT_W'(idx_q);
          end else if (!stay_q) begin
            act = ACT_DONE;
          end else if (wait_c) begin
            act = ACT_WAIT;
            if (!ended_q) begin
              ended_d = 1'b1;
              end_d   = s1_data_q.now_time;
            end
          end else begin
            // open a new uncapped pass
            restart = 1'b1;
            idx_d   = '0;
            first_d = 1'b0;
            start_d = s1_data_q.now_time;
            ended_d = 1'b0;
            end_d   = '0;
            act     = ACT_TRY;
          end
        end
      end
      CMD_FAIL: begin
        if (idx_q < IDX_W'(MAX_NETWORKS)) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      CMD_SUCCESS: begin
        synced_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Time left after the update
  assign left_post = (!first_q || restart) ? NO_CAP_MS :
                     (!started_q ? budget_s : left_started);

  always_comb begin
    tmo_min = (left_post < $signed({{(LEFT_W-CFG_DATA_W){1'b0}}, limit_q})) ?
              left_post : $signed({{(LEFT_W-CFG_DATA_W){1'b0}}, limit_q});
    if (tmo_min < TMO_MIN) begin
      tmo_min = TMO_MIN;
    end
    tmo = tmo_min[31:0];
  end

  always_comb begin
    if (size == '0) begin
      radio = 1'b0;
    end else if (stay_q) begin
      radio = 1'b1;
    end else if (synced_d) begin
      radio = 1'b0;
    end else if (!started_d) begin
      radio = 1'b1;
    end else begin
      radio = !((idx_d >= size) || (left_post <= $signed({LEFT_W{1'b0}})));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      budget_q    <= '0;
      limit_q     <= '0;
      retry_q     <= '0;
      stay_q      <= 1'b0;
      synced_q    <= 1'b0;
      idx_q       <= '0;
      first_q     <= 1'b1;
      start_q     <= '0;
      started_q   <= 1'b0;
      end_q       <= '0;
      ended_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NETWORK_COUNT:     count_q  <= cfg_wdata_i[COUNT_W-1:0];
          CFG_BOOT_BUDGET:       budget_q <= cfg_wdata_i;
          CFG_PER_ATTEMPT_LIMIT: limit_q  <= cfg_wdata_i;
          CFG_RETRY_WAIT:        retry_q  <= cfg_wdata_i;
          CFG_STAY_CONNECTED:    stay_q   <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
      if (s1_adv) begin
        synced_q  <= synced_d;
        idx_q     <= idx_d;
        first_q   <= first_d;
        start_q   <= start_d;
        started_q <= started_d;
        end_q     <= end_d;
        ended_q   <= ended_d;
      end
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv) begin
      out_data_q.action          <= act;
      out_data_q.network_index   <= idx_out;
      out_data_q.attempt_timeout <= tmo;
      out_data_q.radio_on        <= radio;
    end
  end

  a_try_radio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.action == ACT_TRY |-> out_data_o.radio_on)
    else $error("try action without radio");

  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.action != ACT_TRY |-> out_data_o.network_index == '0)
    else $error("network index set on non-try action");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(MAX_NETWORKS))
    else $error("network index beyond list limit");

  a_first_pass_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_q |=> !first_q)
    else $error("first pass re-entered");

endmodule

### sim/network_retry_planner_checker.sv
`timescale 1ns / 1ps

module network_retry_planner_checker #(
  parameter int unsigned MAX_NETWORKS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nrp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nrp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  nrp_pkg::nrp_in_t               in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  nrp_pkg::nrp_out_t              out_data_i,
  output int                             fail_count_o,
  output int                             expected_count_o,
  output int                             checked_count_o,
  output int                             try_count_o,
  output int                             wait_count_o
);

  import nrp_pkg::*;

  localparam longint UncappedMs = 64'sd1 <<< 40;
  localparam longint TimeoutMin = -64'sd2147483648;

  // Register shadows
  logic [4:0]  net_count_q;
  logic [30:0] boot_budget_q;
  logic [30:0] attempt_cap_q;
  logic [30:0] retry_gap_q;
  logic        keep_up_q;

  // Planner state
  logic        synced_q;
  logic [4:0]  cur_idx_q;
  logic        first_pass_q;
  longint      pass_start_ms;
  logic        pass_open_q;
  longint      pass_end_ms;
  logic        pass_closed_q;

  nrp_out_t expected_plans[$];
  nrp_out_t want;
  int       mismatches;
  int       checked;
  int       tries;
  int       waits;

  function automatic int list_len();
    return (int'(net_count_q) > int'(MAX_NETWORKS)) ? int'(MAX_NETWORKS) : int'(net_count_q);
  endfunction

  function automatic longint budget_left(longint t);
    if (!first_pass_q) return UncappedMs;
    if (!pass_open_q) return longint'({33'd0, boot_budget_q});
    return longint'({33'd0, boot_budget_q}) - (t - pass_start_ms);
  endfunction

  function automatic bit pass_finished(longint t);
    return (int'(cur_idx_q) >= list_len()) || (budget_left(t) <= 0);
  endfunction

  function automatic bit radio_demand(longint t);
    if (list_len() == 0) return 1'b0;
    if (keep_up_q) return 1'b1;
    if (synced_q) return 1'b0;
    if (!pass_open_q) return 1'b1;
    return !pass_finished(t);
  endfunction

  // Update the planner state for one request and return the plan it yields
  function automatic nrp_out_t next_plan(nrp_in_t req);
    nrp_out_t   plan;
    longint     t;
    longint     left;
    longint     tmo;
    logic [1:0] act;
    t = longint'({16'd0, req.now_time});
    plan = '0;
    act = ACT_ACK;
    case (req.cmd)
      CMD_ASK: begin
        if (synced_q || list_len() == 0) begin
          act = ACT_DONE;
        end else begin
          if (!pass_open_q) begin
            pass_start_ms = t;
            pass_open_q = 1'b1;
          end
          if (!pass_finished(t)) begin
            act = ACT_TRY;
          end else if (!keep_up_q) begin
            act = ACT_DONE;
          end else begin
            if (!pass_closed_q) begin
              pass_end_ms = t;
              pass_closed_q = 1'b1;
            end
            if (t - pass_end_ms < longint'({33'd0, retry_gap_q})) begin
              act = ACT_WAIT;
            end else begin
              // open an uncapped pass from the top of the list
              cur_idx_q = '0;
              first_pass_q = 1'b0;
              pass_start_ms = t;
              pass_closed_q = 1'b0;
              pass_end_ms = 0;
              act = ACT_TRY;
            end
          end
        end
        if (act == ACT_TRY) plan.network_index = cur_idx_q;
      end
      CMD_FAIL: begin
        if (int'(cur_idx_q) < int'(MAX_NETWORKS)) cur_idx_q = cur_idx_q + 5'd1;
      end
      CMD_SUCCESS: begin
        synced_q = 1'b1;
      end
      default: begin
      end
    endcase
    left = budget_left(t);
    tmo = (left < longint'({33'd0, attempt_cap_q})) ? left : longint'({33'd0, attempt_cap_q});
    if (tmo < TimeoutMin) tmo = TimeoutMin;
    plan.action = act;
    plan.attempt_timeout = tmo[31:0];
    plan.radio_on = radio_demand(t);
    return plan;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                 input logic signed [63:0] exp_val);
    mismatches++;
    $display("[%0t] mismatch in %s at result %0d: got %0d, expected %0d",
             $realtime, what, checked, got, exp_val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_count_q   = '0;
      boot_budget_q = '0;
      attempt_cap_q = '0;
      retry_gap_q   = '0;
      keep_up_q     = 1'b0;
      synced_q      = 1'b0;
      cur_idx_q     = '0;
      first_pass_q  = 1'b1;
      pass_start_ms = 0;
      pass_open_q   = 1'b0;
      pass_end_ms   = 0;
      pass_closed_q = 1'b0;
      expected_plans.delete();
      mismatches = 0;
      checked    = 0;
      tries      = 0;
      waits      = 0;
      fail_count_o     <= 0;
      expected_count_o <= 0;
      checked_count_o  <= 0;
      try_count_o      <= 0;
      wait_count_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NETWORK_COUNT:     net_count_q   = cfg_wdata_i[4:0];
          CFG_BOOT_BUDGET:       boot_budget_q = cfg_wdata_i[30:0];
          CFG_PER_ATTEMPT_LIMIT: attempt_cap_q = cfg_wdata_i[30:0];
          CFG_RETRY_WAIT:        retry_gap_q   = cfg_wdata_i[30:0];
          CFG_STAY_CONNECTED:    keep_up_q     = cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) expected_plans.push_back(next_plan(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_plans.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_data_i.action, -1);
        end else begin
          want = expected_plans.pop_front();
          if (out_data_i.action !== want.action)
            report_mismatch("action", out_data_i.action, want.action);
          if (out_data_i.network_index !== want.network_index)
            report_mismatch("network_index", out_data_i.network_index, want.network_index);
          if (out_data_i.attempt_timeout !== want.attempt_timeout)
            report_mismatch("attempt_timeout", out_data_i.attempt_timeout,
                            want.attempt_timeout);
          if (out_data_i.radio_on !== want.radio_on)
            report_mismatch("radio_on", out_data_i.radio_on, want.radio_on);
          if (want.action == ACT_TRY) tries++;
          if (want.action == ACT_WAIT) waits++;
        end
        checked++;
      end
      fail_count_o     <= mismatches;
      expected_count_o <= expected_plans.size();
      checked_count_o  <= checked;
      try_count_o      <= tries;
      wait_count_o     <= waits;
    end
  end

endmodule

### sim/network_retry_planner_core_test.sv
`timescale 1ns / 1ps

module network_retry_planner_core_test;

  import nrp_pkg::*;

  localparam int unsigned MaxNetworks   = 16;
  localparam int          Latency       = 2;
  localparam int          MaxIdle       = 17;
  localparam int          LongHold      = 300;
  localparam int          Phases        = 10;
  localparam int          ItemsPerPhase = 85;
  localparam logic [30:0] Max31         = 31'h7FFF_FFFF;
  localparam logic [1:0]  CmdUnknown    = 2'd3;
  localparam longint      MaxTime       = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [30:0] count_word;
    logic [30:0] budget_ms;
    logic [30:0] limit_ms;
    logic [30:0] retry_ms;
    logic [30:0] stay_word;
  } plan_cfg_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  nrp_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  nrp_out_t              out_data_o;

  int fail_count;
  int expected_count;
  int checked_count;
  int try_count;
  int wait_count;

  bit        rush      = 1'b0;
  bit        hold_long = 1'b0;
  int        items_sent;
  int        settings_used;
  longint    now_ms;
  plan_cfg_t cur_cfg;

  network_retry_planner_core #(
    .MAX_NETWORKS(MaxNetworks)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  network_retry_planner_checker #(
    .MAX_NETWORKS(MaxNetworks)
  ) i_plan_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .fail_count_o     (fail_count),
    .expected_count_o (expected_count),
    .checked_count_o  (checked_count),
    .try_count_o      (try_count),
    .wait_count_o     (wait_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic plan_cfg_t make_cfg(input logic [30:0] count_word,
                                         input logic [30:0] budget_ms,
                                         input logic [30:0] limit_ms,
                                         input logic [30:0] retry_ms,
                                         input logic [30:0] stay_word);
    plan_cfg_t c;
    c.count_word = count_word;
    c.budget_ms  = budget_ms;
    c.limit_ms   = limit_ms;
    c.retry_ms   = retry_ms;
    c.stay_word  = stay_word;
    return c;
  endfunction

  // Mostly short lists and small times so passes finish and retries come around
  function automatic logic [30:0] pick_ms(input int unsigned small_max);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return Max31;
      2:       return 31'($urandom_range(0, Max31));
      default: return 31'($urandom_range(0, small_max));
    endcase
  endfunction

  function automatic plan_cfg_t pick_config();
    plan_cfg_t c;
    case ($urandom_range(0, 9))
      0:       c.count_word = '0;
      1:       c.count_word = 31'(MaxNetworks);
      2:       c.count_word = 31'($urandom_range(0, Max31));
      default: c.count_word = 31'($urandom_range(1, 6));
    endcase
    c.budget_ms = pick_ms(3000);
    c.limit_ms  = pick_ms(500);
    c.retry_ms  = ($urandom_range(0, 19) == 0) ? Max31 : 31'($urandom_range(0, 2000));
    c.stay_word = {30'($urandom), ($urandom_range(0, 9) < 7)};
    return c;
  endfunction

  task automatic offer(input logic [1:0] cmd, input longint t);
    nrp_in_t req;
    int      gap;
    req.cmd = cmd;
    req.now_time = t[47:0];
    gap = rush ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Hold the input until every outstanding plan is back, then let the pipe settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_count != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input plan_cfg_t c);
    drain_results();
    write_reg(CFG_NETWORK_COUNT, c.count_word);
    write_reg(CFG_BOOT_BUDGET, c.budget_ms);
    write_reg(CFG_PER_ATTEMPT_LIMIT, c.limit_ms);
    write_reg(CFG_RETRY_WAIT, c.retry_ms);
    write_reg(CFG_STAY_CONNECTED, c.stay_word);
    cfg_we_i <= 1'b0;
    cur_cfg = c;
    settings_used++;
  endtask

  // Mostly ask/fail sequences on an advancing clock; the rest is noise
  task automatic random_phase(input int n_items);
    logic [63:0] word;
    logic [1:0]  cmd;
    int          pick;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 12) begin
        word = {$urandom, $urandom};
        case ($urandom_range(0, 5))
          0:       word = '0;
          1:       word = 64'(MaxTime);
          default: begin
          end
        endcase
        offer(2'($urandom_range(0, 3)), longint'(word[47:0]));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 80) now_ms += $urandom_range(0, 300);
        else if (pick < 95) now_ms += $urandom_range(0, cur_cfg.retry_ms);
        else if (pick < 98) now_ms += (64'sd1 <<< 31) + $urandom_range(0, 50);
        else now_ms -= $urandom_range(0, 2000);
        pick = $urandom_range(0, 99);
        if (pick < 55) cmd = CMD_ASK;
        else if (pick < 95) cmd = CMD_FAIL;
        else cmd = CmdUnknown;
        offer(cmd, now_ms);
      end
    end
  endtask

  // Result side: random stalls per result, one long hold-off on request
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = rush ? 0 : $urandom_range(0, MaxIdle);
      if (hold_long) begin
        hold_long = 1'b0;
        stall = LongHold;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    plan_cfg_t c;
    items_sent = 0;
    settings_used = 0;
    cur_cfg = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list right after reset, unknown command at the top of the time range
    offer(CMD_ASK, 0);
    offer(CmdUnknown, MaxTime);

    // first pass under a boot budget, budget running out, time going backwards
    apply_config(make_cfg(3, 1000, 300, 500, 0));
    offer(CMD_ASK, 1000);
    offer(CMD_FAIL, 1100);
    offer(CMD_ASK, 1800);
    offer(CMD_FAIL, 1900);
    offer(CMD_ASK, 2100);
    offer(CMD_ASK, 500);
    offer(CMD_ASK, MaxTime);

    // keep-up mode: wait out the retry gap, then uncapped passes
    apply_config(make_cfg(3, 1000, 300, 500, 1));
    offer(CMD_ASK, 3000);
    offer(CMD_ASK, 3499);
    offer(CMD_ASK, 3500);
    offer(CMD_FAIL, 3510);
    offer(CMD_FAIL, 3520);
    offer(CMD_FAIL, 3530);
    offer(CMD_ASK, 3600);
    offer(CMD_ASK, 4100);
    offer(CMD_ASK, 4150);

    now_ms = 10000;
    for (int phase = 0; phase < Phases; phase++) begin
      if (phase == 0) c = make_cfg(31'(MaxNetworks), Max31, Max31, Max31, 1);
      else if (phase == 1) c = make_cfg(0, 0, 0, 0, 0);
      else if (phase == 2) c = make_cfg(Max31, 2000, 200, 300, Max31);
      else c = pick_config();
      apply_config(c);
      rush = (phase % 3 == 2);
      if (phase == 4) begin
        // stall the result side while offering back to back
        rush = 1'b1;
        hold_long = 1'b1;
      end
      random_phase(ItemsPerPhase / 2);
      if (phase == 4) rush = 1'b0;
      if (phase == 6) drain_results();
      random_phase(ItemsPerPhase - ItemsPerPhase / 2);
    end

    // success is sticky, so report it last
    rush = 1'b0;
    apply_config(make_cfg(4, 5000, 250, 100, 1));
    now_ms += 1000;
    offer(CMD_ASK, now_ms);
    offer(CMD_FAIL, now_ms + 10);
    offer(CMD_ASK, now_ms + 20);
    offer(CMD_SUCCESS, now_ms + 30);
    offer(CMD_ASK, now_ms + 40);
    offer(CMD_FAIL, now_ms + 50);
    offer(CmdUnknown, now_ms + 60);
    offer(CMD_SUCCESS, now_ms + 70);
    apply_config(make_cfg(4, 5000, 250, 100, 0));
    offer(CMD_ASK, now_ms + 80);
    offer(CMD_FAIL, now_ms + 90);
    drain_results();
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d transactions over %0d register settings; %0d results checked",
             items_sent, settings_used, checked_count);
    $display("Plans seen: %0d network tries, %0d retry waits; %0d mismatches",
             try_count, wait_count, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d results still outstanding", expected_count);
    $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
rtl/core/nrp_pkg.sv
rtl/core/network_retry_planner_core.sv
sim/network_retry_planner_checker.sv
sim/network_retry_planner_core_test.sv
